/* design/mavg_pkg.sv */
// Shared types and constants for the moving average filter.
`timescale 1ns / 1ps

package mavg_pkg;

	localparam int MAX_WINDOW_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int              WIN_LEN_W     = 9;
	localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 9'd16;

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_ACCUM  = 6'b000100,
		ST_LOAD   = 6'b001000,
		ST_DIV    = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	typedef struct packed {
		logic clr_en;
		logic accept;
		logic accum;
		logic div_load;
		logic div_step;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_last;
		logic out_free;
	} dp_sts_t;

endpackage

/* design/mavg_ctrl.sv */
// Sequencing state machine of the moving average filter.
`timescale 1ns / 1ps

module mavg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mavg_pkg::dp_sts_t sts,
	output mavg_pkg::dp_cmd_t cmd
);
	import mavg_pkg::*;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_ACCUM;
				end
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				state_d   = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_accept_to_accum: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == ST_ACCUM))
		else $error("accepted beat did not start the accumulate step");

	a_result_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> in_ready)
		else $error("controller not ready after handing over a result");
`endif

endmodule

/* design/mavg_dp.sv */
// Datapath of the moving average filter: sample ring, running total, divider.
`timescale 1ns / 1ps

module mavg_dp #(
	parameter int MAX_WINDOW  = mavg_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mavg_pkg::WIN_LEN_W-1:0]   cfg_wdata,
	input  logic [SAMPLE_BITS-1:0]           in_data,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [SAMPLE_BITS-1:0]           out_data,
	input  mavg_pkg::dp_cmd_t                cmd,
	output mavg_pkg::dp_sts_t                sts
);
	import mavg_pkg::*;

	localparam int POS_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int LEN_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW + 1) : 2;
	localparam int TOT_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
	localparam int CNT_W = $clog2(TOT_W);

	localparam logic [TOT_W-1:0] POS_LIM =
		{{(TOT_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic [TOT_W-1:0] NEG_LIM = POS_LIM + TOT_W'(1);
	localparam logic [SAMPLE_BITS-1:0] MIN_VAL = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

	logic [WIN_LEN_W-1:0]          win_len_q;
	logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] rd_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [POS_W-1:0]              pos_q;
	logic [POS_W-1:0]              clr_addr_q;
	logic signed [TOT_W-1:0]       total_q;
	logic [TOT_W-1:0]              dvd_q;
	logic [LEN_W-1:0]              rem_q;
	logic                          neg_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          out_valid_q;
	logic [SAMPLE_BITS-1:0]        out_data_q;

	logic [LEN_W-1:0]              eff_len;
	logic [LEN_W-1:0]              pos_nxt;
	logic signed [TOT_W-1:0]       sum_new;
	logic [TOT_W-1:0]              abs_tot;
	logic [LEN_W:0]                trial;
	logic [TOT_W-1:0]              neg_mag;
	logic [SAMPLE_BITS-1:0]        avg;

	always_comb begin
		if (win_len_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (32'(win_len_q) > 32'(MAX_WINDOW)) begin
			eff_len = LEN_W'(MAX_WINDOW);
		end else begin
			eff_len = LEN_W'(win_len_q);
		end
	end

	assign pos_nxt = LEN_W'(pos_q) + LEN_W'(1);
	assign sum_new = total_q + TOT_W'(sample_q) - TOT_W'(rd_q);
	assign abs_tot = total_q[TOT_W-1] ? TOT_W'(-total_q) : TOT_W'(total_q);
	assign trial   = {rem_q, dvd_q[TOT_W-1]} - {1'b0, eff_len};
	assign neg_mag = -dvd_q;

	always_comb begin
		if (neg_q) begin
			avg = (dvd_q > NEG_LIM) ? MIN_VAL : neg_mag[SAMPLE_BITS-1:0];
		end else begin
			avg = (dvd_q > POS_LIM) ? POS_LIM[SAMPLE_BITS-1:0] : dvd_q[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_en) begin
			ring_mem[clr_addr_q] <= '0;
		end else if (cmd.accum) begin
			ring_mem[pos_q] <= sample_q;
		end
		if (cmd.accept) begin
			rd_q <= ring_mem[pos_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= signed'(in_data);
		end
		if (cmd.div_load) begin
			dvd_q <= abs_tot;
			rem_q <= '0;
			neg_q <= total_q[TOT_W-1];
		end else if (cmd.div_step) begin
			if (!trial[LEN_W]) begin
				rem_q <= trial[LEN_W-1:0];
			end else begin
				rem_q <= {rem_q[LEN_W-2:0], dvd_q[TOT_W-1]};
			end
			dvd_q <= {dvd_q[TOT_W-2:0], !trial[LEN_W]};
		end
		if (cmd.out_load) begin
			out_data_q <= avg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q   <= WIN_LEN_RESET;
			pos_q       <= '0;
			clr_addr_q  <= '0;
			total_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				win_len_q <= cfg_wdata;
			end
			if (cmd.clr_en) begin
				clr_addr_q <= clr_addr_q + POS_W'(1);
			end
			if (cmd.accum) begin
				total_q <= sum_new;
				if (pos_nxt >= eff_len) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_nxt[POS_W-1:0];
				end
			end
			if (cmd.div_load) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clr_last = (clr_addr_q == POS_W'(MAX_WINDOW - 1));
	assign sts.div_last = (cnt_q == CNT_W'(TOT_W - 1));
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_load_into_free_reg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken beat");

	a_clear_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clr_en && !sts.clr_last) |=> (clr_addr_q == $past(clr_addr_q) + POS_W'(1)))
		else $error("clearing pass skipped or repeated an entry");
`endif

endmodule

/* design/moving_average_filter.sv */
// Top level of the moving average filter.
`timescale 1ns / 1ps

// Moving average over the last window_len signed samples.
// Input stream s_*: one sample per beat. Output stream m_*: one average per
// input beat, the running total divided by the window length, truncated
// toward zero and saturated to the sample range.
// The window length is written through cfg_we / cfg_wdata while the block is
// idle; a reset afterwards restores length 16 and an all-zero sample history.
// Each sample passes through an accumulate step, a divider load step, one
// restoring-divider iteration per bit of the running total (24 at the default
// sizes) and a step that loads the output register; a new sample is taken
// only once the previous result has been loaded into the output register.
// After reset the sample ring is cleared one entry per cycle, all MAX_WINDOW
// entries (256 by default), with s_tready low; configuration writes are taken.
// The output register holds a result until m_tready takes it, and the next
// sample is accepted meanwhile; if the result is still untaken when the next
// one is ready, the block waits with s_tready low.
module moving_average_filter #(
	parameter int MAX_WINDOW  = mavg_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [mavg_pkg::WIN_LEN_W-1:0]        cfg_wdata,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((SAMPLE_BITS + 7) / 8)*8-1:0]  s_tdata,  // sample
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((SAMPLE_BITS + 7) / 8)*8-1:0]  m_tdata   // average
);
	import mavg_pkg::*;

	localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

	dp_cmd_t                cmd;
	dp_sts_t                sts;
	logic [SAMPLE_BITS-1:0] out_data;

	mavg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mavg_dp #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_tdata[SAMPLE_BITS-1:0]),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

	assign m_tdata = DATA_W'(out_data);

endmodule

/* bench/moving_average_filter_tb.sv */
// Self-checking testbench for the moving average filter with a built-in window predictor.
`timescale 1ns / 1ps

module moving_average_filter_tb;

	import mavg_pkg::*;

	localparam int RING_DEPTH  = MAX_WINDOW_DEF;
	localparam int RANDOM_ITEMS = 1700;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CAP    = 20000;
	localparam int HOLD_CYCLES  = 600;
	localparam int TAIL_CYCLES  = 40;

	typedef struct {
		bit                   new_win;
		logic [WIN_LEN_W-1:0] win;
		logic [15:0]          smp;
		bit                   typed;
		logic [15:0]          want;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [WIN_LEN_W-1:0] cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata = '0;    // sample
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [15:0]          m_tdata;         // average

	logic signed [15:0]   hist_ring [RING_DEPTH];
	int unsigned          hist_pos = 0;
	longint               hist_total = 0;
	logic [WIN_LEN_W-1:0] win_setting = WIN_LEN_RESET;

	logic [15:0] expected_averages [$];
	int          mismatches = 0;
	int          cycle_count = 0;
	bit          quiet = 1'b0;
	bit          hold_request = 1'b0;

	dir_row_t dir_rows [21] = '{
		'{1'b0, 9'd0,   16'hFFF1, 1'b1, 16'h0000},
		'{1'b0, 9'd0,   16'h000F, 1'b1, 16'h0000},
		'{1'b0, 9'd0,   16'h8000, 1'b1, 16'hF800},
		'{1'b0, 9'd0,   16'h7FFF, 1'b1, 16'h0000},
		'{1'b1, 9'd0,   16'h7FFF, 1'b0, 16'h0000},
		'{1'b0, 9'd0,   16'h7FFF, 1'b0, 16'h0000},
		'{1'b0, 9'd0,   16'h8000, 1'b0, 16'h0000},
		'{1'b0, 9'd0,   16'h8000, 1'b0, 16'h0000},
		'{1'b0, 9'd0,   16'h8000, 1'b0, 16'h0000},
		'{1'b1, 9'd511, 16'h8000, 1'b0, 16'h0000},
		'{1'b0, 9'd0,   16'h7FFF, 1'b0, 16'h0000},
		'{1'b0, 9'd0,   16'h0001, 1'b0, 16'h0000},
		'{1'b0, 9'd0,   16'hFFFF, 1'b0, 16'h0000},
		'{1'b1, 9'd256, 16'h7FFF, 1'b0, 16'h0000},
		'{1'b0, 9'd0,   16'h8000, 1'b0, 16'h0000},
		'{1'b0, 9'd0,   16'h5555, 1'b0, 16'h0000},
		'{1'b0, 9'd0,   16'hAAAA, 1'b0, 16'h0000},
		'{1'b1, 9'd1,   16'h8000, 1'b0, 16'h0000},
		'{1'b0, 9'd0,   16'h7FFF, 1'b0, 16'h0000},
		'{1'b0, 9'd0,   16'h0000, 1'b0, 16'h0000},
		'{1'b1, 9'd257, 16'hFFF9, 1'b0, 16'h0000}
	};

	moving_average_filter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [15:0] next_average(input logic [15:0] smp);
		int unsigned n;
		longint      v;
		longint      q;
		n = (win_setting == '0) ? 1 :
			((int'(win_setting) > RING_DEPTH) ? RING_DEPTH : int'(win_setting));
		if (hist_pos >= RING_DEPTH) begin
			hist_pos = 0;
		end
		v = longint'($signed(smp));
		hist_total += v - longint'(hist_ring[hist_pos]);
		q = hist_total / longint'(n);
		if (q > 32767) begin
			q = 32767;
		end
		if (q < -32768) begin
			q = -32768;
		end
		hist_ring[hist_pos] = $signed(smp);
		hist_pos++;
		if (hist_pos >= n) begin
			hist_pos = 0;
		end
		return q[15:0];
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < 40) begin
			$display("ERROR at %0t: %s", $realtime, msg);
		end
		mismatches++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic send_sample(input logic [15:0] smp, input bit typed, input logic [15:0] want);
		int          gap;
		logic [15:0] predicted;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = next_average(smp);
		expected_averages.push_back(typed ? want : predicted);
	endtask

	task automatic wait_drained();
		int waited;
		waited = 0;
		while (expected_averages.size() != 0 && waited < DRAIN_CAP) begin
			@(posedge clk);
			waited++;
		end
		if (expected_averages.size() != 0) begin
			report_mismatch($sformatf("%0d averages never arrived", expected_averages.size()));
			expected_averages.delete();
		end
	endtask

	task automatic set_window(input logic [WIN_LEN_W-1:0] w);
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(negedge clk);
		cfg_we <= 1'b0;
		win_setting = w;
	endtask

	function automatic logic [WIN_LEN_W-1:0] pick_window();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 9'd0;
			1: return 9'd1;
			2: return 9'd256;
			3: return 9'd511;
			4: return WIN_LEN_W'($urandom_range(257, 511));
			5, 6: return WIN_LEN_W'($urandom_range(2, 8));
			7, 8: return WIN_LEN_W'($urandom_range(9, 64));
			default: return WIN_LEN_W'($urandom_range(65, 255));
		endcase
	endfunction

	function automatic logic [15:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 15) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		foreach (hist_ring[i]) begin
			hist_ring[i] = '0;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// The receiver mixes random ready and stalled runs; a hold request forces one long stall.
	initial begin
		int   len;
		int   r;
		logic level;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				level = 1'b0;
				len   = HOLD_CYCLES;
			end else if (quiet) begin
				level = 1'b1;
				len   = 1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					level = 1'b1;
					len   = $urandom_range(1, 30);
				end else begin
					level = 1'b0;
					r = $urandom_range(0, 99);
					len = (r < 80) ? $urandom_range(1, 3) :
						(r < 95) ? $urandom_range(4, 15) : $urandom_range(30, 80);
				end
			end
			repeat (len) begin
				@(negedge clk);
				m_tready <= level;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_averages.size() == 0) begin
				report_mismatch($sformatf("average %0d with no sample pending",
					$signed(m_tdata)));
			end else begin
				if (m_tdata !== expected_averages[0]) begin
					report_mismatch($sformatf("average got %0d expected %0d",
						$signed(m_tdata), $signed(expected_averages[0])));
				end
				void'(expected_averages.pop_front());
			end
		end
	end

	initial begin
		int sent;
		int phase;
		int phase_len;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].new_win) begin
				set_window(dir_rows[i].win);
			end
			send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
		end

		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			set_window(pick_window());
			phase_len = $urandom_range(15, 150);
			quiet = ($urandom_range(0, 5) == 0);
			if (phase == 2) begin
				quiet        = 1'b0;
				phase_len    = 80;
				hold_request = 1'b1;
			end
			if (phase_len > RANDOM_ITEMS - sent) begin
				phase_len = RANDOM_ITEMS - sent;
			end
			repeat (phase_len) begin
				send_sample(pick_sample(), 1'b0, 16'h0000);
				sent++;
			end
			phase++;
		end
		@(negedge clk);
		s_tvalid <= 1'b0;
		quiet = 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/mavg_pkg.sv
design/mavg_ctrl.sv
design/mavg_dp.sv
design/moving_average_filter.sv
bench/moving_average_filter_tb.sv
